// ===== src/rfos_pkg.sv =====
package rfos_pkg;

	localparam int DEPTH_DEF = 16;
	localparam int WIDTH_DEF = 32;

	// Configuration register indexes
	localparam int CFG_IDX_W     = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_SLOTS     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_OVERWRITE = 2'd1;

	// Command opcodes
	localparam logic [1:0] OP_PUSH = 2'd0;
	localparam logic [1:0] OP_POP  = 2'd1;
	localparam logic [1:0] OP_SNAP = 2'd2;

	typedef enum logic [1:0] {
		K_PUSH,
		K_POP,
		K_SNAP,
		K_FAIL
	} cmd_kind_t;

	typedef struct packed {
		logic      emit;
		cmd_kind_t kind;
		logic      snap_next;
		logic      last;
	} cmd_t;

endpackage

// ===== src/rfos_ctrl.sv =====
module rfos_ctrl
	import rfos_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [1:0]                      opcode,
	input  logic [$clog2(DEPTH+1)-1:0]      snap_n,
	output logic                            busy,
	output cmd_t                            cmd
);

	localparam int CNT_W = $clog2(DEPTH + 1);

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_SNAP = 2'b10
	} state_t;

	state_t             state_q, state_d;
	logic [CNT_W-1:0]   left_q, left_d;

	always_comb begin
		cmd.emit      = 1'b0;
		cmd.kind      = K_FAIL;
		cmd.snap_next = 1'b0;
		cmd.last      = 1'b1;
		state_d       = state_q;
		left_d        = left_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.emit = 1'b1;
					unique case (opcode)
						OP_PUSH: cmd.kind = K_PUSH;
						OP_POP:  cmd.kind = K_POP;
						OP_SNAP: begin
							// nothing to return falls through as a failed beat
							if (snap_n != '0) begin
								cmd.kind = K_SNAP;
								cmd.last = (snap_n == CNT_W'(1));
								left_d   = snap_n - CNT_W'(1);
								if (snap_n != CNT_W'(1))
									state_d = S_SNAP;
							end
						end
						default: cmd.kind = K_FAIL;
					endcase
				end
			end
			S_SNAP: begin
				cmd.emit      = 1'b1;
				cmd.kind      = K_SNAP;
				cmd.snap_next = 1'b1;
				cmd.last      = (left_q == CNT_W'(1));
				left_d        = left_q - CNT_W'(1);
				if (left_q == CNT_W'(1))
					state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			left_q  <= '0;
		end else begin
			state_q <= state_d;
			left_q  <= left_d;
		end
	end

	assign busy = (state_q == S_SNAP);

`ifndef SYNTHESIS
	a_snap_left: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SNAP) |-> (left_q != '0))
		else $error("snapshot streaming with no beats left");

	a_snap_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SNAP && left_q == CNT_W'(1)) |=> (state_q == S_IDLE))
		else $error("snapshot did not end after its last beat");

	a_busy_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> ($past(start) && $past(opcode) == OP_SNAP
			&& $past(snap_n) > CNT_W'(1)))
		else $error("busy raised without a multi-beat snapshot");
`endif

endmodule

// ===== src/rfos_dp.sv =====
module rfos_dp
	import rfos_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF,
	parameter int WIDTH = WIDTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  cmd_t                            cmd,
	input  logic [WIDTH-1:0]                data_in,
	input  logic [$clog2(DEPTH+1)-1:0]      snap_limit,
	input  logic                            cfg_we,
	input  logic [CFG_IDX_W-1:0]            cfg_index,
	input  logic [$clog2(DEPTH+1)-1:0]      cfg_data,
	output logic [$clog2(DEPTH+1)-1:0]      snap_n,
	output logic                            result_valid,
	output logic                            ok,
	output logic [WIDTH-1:0]                data_out,
	output logic                            item_valid,
	output logic                            last,
	output logic [$clog2(DEPTH+1)-1:0]      fill_count,
	output logic                            dropped_oldest
);

	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [WIDTH-1:0]  mem [DEPTH];
	logic [WIDTH-1:0]  rdata_q;

	logic [CNT_W-1:0]  slots_q;
	logic              ovw_q;
	logic [PTR_W-1:0]  rptr_q, wptr_q, sp_q;
	logic [CNT_W-1:0]  held_q;

	logic [PTR_W-1:0]  raddr, rptr_d, wptr_d;
	logic [CNT_W-1:0]  held_d, slots_sat;
	logic              full, empty, do_push, do_pop, do_drop, res_ok;

	function automatic logic [PTR_W-1:0] adv(input logic [PTR_W-1:0] p,
	                                         input logic [CNT_W-1:0] slots);
		logic [CNT_W:0] nxt;
		nxt = (CNT_W+1)'(p) + (CNT_W+1)'(1);
		return (nxt >= {1'b0, slots}) ? '0 : PTR_W'(nxt);
	endfunction

	assign full    = (held_q >= slots_q);
	assign empty   = (held_q == '0);
	assign snap_n  = (snap_limit < held_q) ? snap_limit : held_q;

	assign do_push = cmd.emit && (cmd.kind == K_PUSH) && (!full || ovw_q);
	assign do_drop = cmd.emit && (cmd.kind == K_PUSH) && full && ovw_q;
	assign do_pop  = cmd.emit && (cmd.kind == K_POP) && !empty;
	assign raddr   = cmd.snap_next ? sp_q : rptr_q;

	always_comb begin
		rptr_d = rptr_q;
		wptr_d = wptr_q;
		held_d = held_q;
		if (do_drop || do_pop)
			rptr_d = adv(rptr_q, slots_q);
		if (do_push)
			wptr_d = adv(wptr_q, slots_q);
		if (do_push && !do_drop)
			held_d = held_q + CNT_W'(1);
		else if (do_pop)
			held_d = held_q - CNT_W'(1);
	end

	always_comb begin
		unique case (cmd.kind)
			K_PUSH:  res_ok = !full || ovw_q;
			K_POP:   res_ok = !empty;
			K_SNAP:  res_ok = 1'b1;
			default: res_ok = 1'b0;
		endcase
	end

	// Clamp capacity into 1..DEPTH
	always_comb begin
		if (cfg_data == '0)
			slots_sat = CNT_W'(1);
		else if (cfg_data > CNT_W'(DEPTH))
			slots_sat = CNT_W'(DEPTH);
		else
			slots_sat = cfg_data;
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
		if (do_push)
			mem[wptr_q] <= data_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slots_q      <= CNT_W'(DEPTH);
			ovw_q        <= 1'b0;
			rptr_q       <= '0;
			wptr_q       <= '0;
			held_q       <= '0;
			result_valid <= 1'b0;
		end else begin
			result_valid <= cmd.emit;
			if (cfg_we && cfg_index == CFG_SLOTS) begin
				slots_q <= slots_sat;
				rptr_q  <= '0;
				wptr_q  <= '0;
				held_q  <= '0;
			end else begin
				rptr_q <= rptr_d;
				wptr_q <= wptr_d;
				held_q <= held_d;
			end
			if (cfg_we && cfg_index == CFG_OVERWRITE)
				ovw_q <= cfg_data[0];
		end
	end

	// Result beat and snapshot walk pointer
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			ok             <= res_ok;
			item_valid     <= (cmd.kind == K_SNAP) || do_pop;
			last           <= cmd.last;
			fill_count     <= held_d;
			dropped_oldest <= do_drop;
		end
		if (cmd.kind == K_SNAP)
			sp_q <= adv(raddr, slots_q);
	end

	assign data_out = item_valid ? rdata_q : '0;

endmodule

// ===== src/ring_fifo_overwrite_snapshot.sv =====
// Ring FIFO of WIDTH-bit elements with overwrite-on-full and a non-destructive
// snapshot read. A command is taken when start is high and busy is low; its
// result beat appears on the cycle after, marked by result_valid for exactly
// one cycle, and cannot be held off. Push, pop and any failing command give one
// beat and leave busy low, so a new command can be issued every cycle. A
// snapshot returning n elements gives n beats on consecutive cycles, one
// element per cycle through the single read port of the slot store, and keeps
// busy high until its last beat is issued. Writing slots_in_use (index
// 0) empties the FIFO; overwrite_enable is index 1. Write configuration only
// while no snapshot is in progress and never in the cycle a command is taken.
module ring_fifo_overwrite_snapshot
	import rfos_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF,
	parameter int WIDTH = WIDTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic [1:0]                      opcode,
	input  logic [WIDTH-1:0]                data_in,
	input  logic [$clog2(DEPTH+1)-1:0]      snap_limit,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [CFG_IDX_W-1:0]            cfg_index,
	input  logic [$clog2(DEPTH+1)-1:0]      cfg_data,
	output logic                            result_valid,
	output logic                            ok,
	output logic [WIDTH-1:0]                data_out,
	output logic                            item_valid,
	output logic                            last,
	output logic [$clog2(DEPTH+1)-1:0]      fill_count,
	output logic                            dropped_oldest
);

	localparam int CNT_W = $clog2(DEPTH + 1);

	cmd_t              cmd;
	logic [CNT_W-1:0]  snap_n;

	assign cfg_ready = !busy;

	rfos_ctrl #(
		.DEPTH (DEPTH)
	) u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.opcode (opcode),
		.snap_n (snap_n),
		.busy   (busy),
		.cmd    (cmd)
	);

	rfos_dp #(
		.DEPTH (DEPTH),
		.WIDTH (WIDTH)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.data_in        (data_in),
		.snap_limit     (snap_limit),
		.cfg_we         (cfg_valid && cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.snap_n         (snap_n),
		.result_valid   (result_valid),
		.ok             (ok),
		.data_out       (data_out),
		.item_valid     (item_valid),
		.last           (last),
		.fill_count     (fill_count),
		.dropped_oldest (dropped_oldest)
	);

endmodule

// ===== sim/tb_top.sv =====
module tb_top
	import rfos_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH = DEPTH_DEF;
	localparam int WIDTH = WIDTH_DEF;
	localparam int CNT_W = $clog2(DEPTH + 1);

	// opcode and register indexes outside the defined set
	localparam logic [1:0]           OP_UNUSED = 2'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

	typedef struct {
		logic             ok;
		logic [WIDTH-1:0] data;
		logic             item_valid;
		logic             last;
		logic [CNT_W-1:0] fill;
		logic             dropped;
	} fifo_beat_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 start = 1'b0;
	logic                 busy;
	logic [1:0]           opcode = OP_PUSH;
	logic [WIDTH-1:0]     data_in = '0;
	logic [CNT_W-1:0]     snap_limit = '0;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_SLOTS;
	logic [CNT_W-1:0]     cfg_data = '0;
	logic                 result_valid;
	logic                 ok;
	logic [WIDTH-1:0]     data_out;
	logic                 item_valid;
	logic                 last;
	logic [CNT_W-1:0]     fill_count;
	logic                 dropped_oldest;

	ring_fifo_overwrite_snapshot #(
		.DEPTH(DEPTH),
		.WIDTH(WIDTH)
	) i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.opcode        (opcode),
		.data_in       (data_in),
		.snap_limit    (snap_limit),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.result_valid  (result_valid),
		.ok            (ok),
		.data_out      (data_out),
		.item_valid    (item_valid),
		.last          (last),
		.fill_count    (fill_count),
		.dropped_oldest(dropped_oldest)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// shadow of the FIFO
	logic [WIDTH-1:0] shadow_store [DEPTH];
	int unsigned      shadow_rd;
	int unsigned      shadow_wr;
	int unsigned      shadow_held;
	int unsigned      shadow_slots;
	bit               shadow_overwrite;

	fifo_beat_t pending_beats[$];
	fifo_beat_t seen_beat;
	fifo_beat_t want_beat;

	int  errors;
	int  n_push, n_pop, n_snap, n_unused, n_beats, n_cfg;
	bit  quiet;

	task automatic report_mismatch(input string msg);
		$display("%0t ns MISMATCH: %s", $realtime, msg);
		errors++;
	endtask

	function automatic int unsigned ring_next(input int unsigned p);
		return (p + 1 >= shadow_slots) ? 0 : p + 1;
	endfunction

	function automatic fifo_beat_t make_beat(input logic okv, input logic [WIDTH-1:0] d,
			input logic iv, input logic lst, input logic drp);
		fifo_beat_t b;
		b.ok = okv;
		b.data = d;
		b.item_valid = iv;
		b.last = lst;
		b.fill = shadow_held[CNT_W-1:0];
		b.dropped = drp;
		return b;
	endfunction

	function automatic void predict_fifo_op(input logic [1:0] op, input logic [WIDTH-1:0] din,
			input logic [CNT_W-1:0] maxn);
		int unsigned n;
		int unsigned p;
		bit          drp;
		drp = 1'b0;
		case (op)
			OP_PUSH: begin
				if (shadow_held >= shadow_slots && !shadow_overwrite) begin
					pending_beats.push_back(make_beat(1'b0, '0, 1'b0, 1'b1, 1'b0));
				end else begin
					if (shadow_held >= shadow_slots) begin
						shadow_rd = ring_next(shadow_rd);
						shadow_held--;
						drp = 1'b1;
					end
					shadow_store[shadow_wr] = din;
					shadow_wr = ring_next(shadow_wr);
					shadow_held++;
					pending_beats.push_back(make_beat(1'b1, '0, 1'b0, 1'b1, drp));
				end
			end
			OP_POP: begin
				if (shadow_held == 0) begin
					pending_beats.push_back(make_beat(1'b0, '0, 1'b0, 1'b1, 1'b0));
				end else begin
					p = shadow_rd;
					shadow_rd = ring_next(shadow_rd);
					shadow_held--;
					pending_beats.push_back(make_beat(1'b1, shadow_store[p], 1'b1, 1'b1, 1'b0));
				end
			end
			OP_SNAP: begin
				n = (shadow_held < maxn) ? shadow_held : maxn;
				if (n > DEPTH)
					n = DEPTH;
				if (n == 0) begin
					pending_beats.push_back(make_beat(1'b0, '0, 1'b0, 1'b1, 1'b0));
				end else begin
					p = shadow_rd;
					for (int i = 0; i < n; i++) begin
						pending_beats.push_back(make_beat(1'b1, shadow_store[p], 1'b1,
							(i + 1 == n), 1'b0));
						p = ring_next(p);
					end
				end
			end
			default: begin
				pending_beats.push_back(make_beat(1'b0, '0, 1'b0, 1'b1, 1'b0));
			end
		endcase
	endfunction

	// check every result beat against the oldest prediction
	always @(posedge clk) begin
		if (arst_n && result_valid) begin
			seen_beat = '{ok, data_out, item_valid, last, fill_count, dropped_oldest};
			n_beats++;
			if (pending_beats.size() == 0) begin
				report_mismatch("result beat with nothing predicted");
			end else begin
				want_beat = pending_beats.pop_front();
				if (seen_beat.ok !== want_beat.ok)
					report_mismatch($sformatf("ok %b, want %b", seen_beat.ok, want_beat.ok));
				if (seen_beat.data !== want_beat.data)
					report_mismatch($sformatf("data_out %h, want %h",
						seen_beat.data, want_beat.data));
				if (seen_beat.item_valid !== want_beat.item_valid)
					report_mismatch($sformatf("item_valid %b, want %b",
						seen_beat.item_valid, want_beat.item_valid));
				if (seen_beat.last !== want_beat.last)
					report_mismatch($sformatf("last %b, want %b",
						seen_beat.last, want_beat.last));
				if (seen_beat.fill !== want_beat.fill)
					report_mismatch($sformatf("fill_count %0d, want %0d",
						seen_beat.fill, want_beat.fill));
				if (seen_beat.dropped !== want_beat.dropped)
					report_mismatch($sformatf("dropped_oldest %b, want %b",
						seen_beat.dropped, want_beat.dropped));
			end
		end
	end

	// call at a rising edge; returns at the edge that takes the command
	task automatic send_cmd(input logic [1:0] op, input logic [WIDTH-1:0] din,
			input logic [CNT_W-1:0] maxn);
		start <= 1'b1;
		opcode <= op;
		data_in <= din;
		snap_limit <= maxn;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		predict_fifo_op(op, din, maxn);
		case (op)
			OP_PUSH: n_push++;
			OP_POP:  n_pop++;
			OP_SNAP: n_snap++;
			default: n_unused++;
		endcase
	endtask

	task automatic idle_for(input int cycles);
		start <= 1'b0;
		repeat (cycles)
			@(posedge clk);
	endtask

	task automatic maybe_idle();
		if (!quiet && $urandom_range(0, 5) == 0)
			idle_for($urandom_range(1, 16));
	endtask

	// hold the sender until every predicted beat has arrived or the guard limit is reached
	task automatic wait_drained(input int limit);
		int guard;
		guard = 0;
		start <= 1'b0;
		while (pending_beats.size() != 0 && guard < limit) begin
			@(posedge clk);
			guard++;
		end
		repeat (3)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CNT_W-1:0] val);
		int unsigned v;
		wait_drained(5000);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		n_cfg++;
		case (idx)
			CFG_SLOTS: begin
				v = val;
				if (v == 0)
					v = 1;
				if (v > DEPTH)
					v = DEPTH;
				shadow_slots = v;
				shadow_rd = 0;
				shadow_wr = 0;
				shadow_held = 0;
			end
			CFG_OVERWRITE: shadow_overwrite = val[0];
			default: ;
		endcase
	endtask

	task automatic test_empty_and_edges();
		send_cmd(OP_POP, 32'h0, 5'd0);
		send_cmd(OP_SNAP, 32'h0, 5'd5);
		send_cmd(OP_UNUSED, 32'hFFFF_FFFF, 5'd31);
		send_cmd(OP_PUSH, 32'h0000_0000, 5'd0);
		send_cmd(OP_PUSH, 32'hFFFF_FFFF, 5'd31);
		send_cmd(OP_SNAP, 32'h0, 5'd0);
		send_cmd(OP_SNAP, 32'hFFFF_FFFF, 5'd31);
		send_cmd(OP_POP, 32'h0, 5'd0);
		send_cmd(OP_POP, 32'h0, 5'd0);
		send_cmd(OP_POP, 32'h0, 5'd0);
	endtask

	task automatic test_full_and_overwrite();
		write_reg(CFG_SLOTS, 5'd2);
		send_cmd(OP_PUSH, 32'hA5A5_0001, 5'd0);
		send_cmd(OP_PUSH, 32'h5A5A_0002, 5'd0);
		// full with overwrite off: refuse
		send_cmd(OP_PUSH, 32'hDEAD_0003, 5'd0);
		write_reg(CFG_OVERWRITE, 5'b11111);
		send_cmd(OP_PUSH, 32'hBEEF_0004, 5'd0);
		send_cmd(OP_SNAP, 32'h0, 5'd16);
		send_cmd(OP_POP, 32'h0, 5'd0);
	endtask

	task automatic test_capacity_limits();
		// zero capacity saturates to one slot
		write_reg(CFG_SLOTS, 5'd0);
		send_cmd(OP_PUSH, 32'h1234_5678, 5'd0);
		send_cmd(OP_PUSH, 32'h8765_4321, 5'd0);
		send_cmd(OP_SNAP, 32'h0, 5'd1);
		write_reg(CFG_SPARE_A, 5'b10101);
		write_reg(CFG_SPARE_B, 5'b01010);
		send_cmd(OP_SNAP, 32'h0, 5'd3);
		write_reg(CFG_SLOTS, 5'd31);
		write_reg(CFG_OVERWRITE, 5'b11110);
		send_cmd(OP_POP, 32'h0, 5'd0);
	endtask

	task automatic random_item(input int push_w);
		int               r;
		logic [1:0]       op;
		logic [WIDTH-1:0] d;
		r = $urandom_range(0, 99);
		if (r < push_w)
			op = OP_PUSH;
		else if (r < push_w + 25)
			op = OP_POP;
		else if (r < 97)
			op = OP_SNAP;
		else
			op = OP_UNUSED;
		case ($urandom_range(0, 9))
			0: d = '0;
			1: d = '1;
			default: d = $urandom;
		endcase
		send_cmd(op, d, CNT_W'($urandom_range(0, 31)));
	endtask

	task automatic test_random_traffic();
		logic [CNT_W-1:0] caps [6];
		int               items;
		int               pause_at;
		int               push_w;
		bit               idle_on;
		caps = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd0, 5'd0};
		caps[4] = CNT_W'($urandom_range(2, 15));
		caps[5] = CNT_W'($urandom_range(0, 31));
		for (int ph = 0; ph < 6; ph++) begin
			write_reg(CFG_SLOTS, caps[ph]);
			write_reg(CFG_OVERWRITE, CNT_W'($urandom_range(0, 31)));
			items = $urandom_range(35, 50);
			pause_at = $urandom_range(5, items - 5);
			push_w = $urandom_range(30, 65);
			idle_on = ($urandom_range(0, 3) != 0);
			for (int i = 0; i < items; i++) begin
				random_item(push_w);
				if (i == pause_at)
					wait_drained(5000);
				else if (idle_on)
					maybe_idle();
			end
		end
	endtask

	task automatic test_back_to_back();
		quiet = 1'b1;
		write_reg(CFG_SLOTS, CNT_W'($urandom_range(4, 16)));
		write_reg(CFG_OVERWRITE, 5'd1);
		for (int i = 0; i < 40; i++)
			random_item(50);
	endtask

	initial begin
		errors = 0;
		quiet = 1'b0;
		shadow_rd = 0;
		shadow_wr = 0;
		shadow_held = 0;
		shadow_slots = DEPTH;
		shadow_overwrite = 1'b0;
		repeat (7)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_and_edges();
		test_full_and_overwrite();
		test_capacity_limits();
		test_random_traffic();
		test_back_to_back();

		wait_drained(5000);
		repeat (20)
			@(posedge clk);
		if (pending_beats.size() != 0)
			report_mismatch($sformatf("%0d predicted beats never arrived",
				pending_beats.size()));
		$display("Covered %0d pushes, %0d pops, %0d snapshots, %0d unused opcodes",
			n_push, n_pop, n_snap, n_unused);
		$display("Checked %0d result beats across %0d register writes, %0d mismatches",
			n_beats, n_cfg, errors);
		if (errors == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ===== files.f =====
src/rfos_pkg.sv
src/rfos_ctrl.sv
src/rfos_dp.sv
src/ring_fifo_overwrite_snapshot.sv
sim/tb_top.sv
